@@ rtl/slm_pkg.sv @@
// Shared constants, codes and state type of the stereo level meter.
`timescale 1ns / 1ps
package slm_pkg;

	// Fixed field widths.
	localparam int SAMPLE_BITS   = 24;
	localparam int LEVEL_W       = 24;
	localparam int CORR_W        = 16;
	localparam int COEF_W        = 17;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 24;
	localparam int CORR_QW       = 15;
	localparam int BLOCK_MAX_DEF = 4096;

	// Fixed-point constants.
	localparam logic [COEF_W-1:0]        UNITY_Q16 = 17'd65536;
	localparam logic [COEF_W-1:0]        CORR_COEF = 17'd3277;
	localparam logic signed [CORR_W-1:0] CORR_ONE  = 16'sd16384;

	// Item opcodes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEREO_MODE,
		CFG_RMS_SMOOTHING,
		CFG_PEAK_FALLOFF,
		CFG_HOLD_FALLOFF
	} cfg_idx_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_L,
		ST_SQ_R,
		ST_SQ_X,
		ST_ACC_X,
		ST_DIV_L,
		ST_RT_L,
		ST_DIV_R,
		ST_RT_R,
		ST_CMUL,
		ST_CRT,
		ST_CDIV,
		ST_SM_L,
		ST_SM_R,
		ST_SM_C,
		ST_TICK,
		ST_OUT
	} state_t;

endpackage

@@ rtl/slm_in_if.sv @@
// Input channel carrying sample pairs and decay ticks.
`timescale 1ns / 1ps
interface slm_in_if import slm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic                          last_in_block;

	modport source (output valid, opcode, left_sample, right_sample, last_in_block,
		input ready);
	modport sink (input valid, opcode, left_sample, right_sample, last_in_block,
		output ready);
endinterface

@@ rtl/slm_out_if.sv @@
// Result channel carrying the meter levels.
`timescale 1ns / 1ps
interface slm_out_if import slm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [LEVEL_W-1:0]       peak_left;
	logic [LEVEL_W-1:0]       peak_right;
	logic [LEVEL_W-1:0]       hold_left;
	logic [LEVEL_W-1:0]       hold_right;
	logic [LEVEL_W-1:0]       rms_left_out;
	logic [LEVEL_W-1:0]       rms_right_out;
	logic signed [CORR_W-1:0] stereo_correlation;

	modport source (output valid, peak_left, peak_right, hold_left, hold_right,
		rms_left_out, rms_right_out, stereo_correlation, input ready);
	modport sink (input valid, peak_left, peak_right, hold_left, hold_right,
		rms_left_out, rms_right_out, stereo_correlation, output ready);
endinterface

@@ rtl/slm_cfg_if.sv @@
// Configuration write channel.
`timescale 1ns / 1ps
interface slm_cfg_if import slm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/stereo_level_meter_top.sv @@
// Stereo peak, hold, RMS and correlation meter with bit-serial block-end arithmetic.
//
//  channel     role    transfer carries
//  sample_ch   sink    opcode, left_sample, right_sample, last_in_block
//  result_ch   source  peak, hold and RMS levels per channel, stereo_correlation
//  cfg_ch      sink    register index and write data, always ready
//
// A sample that does not end a block passes through the accept cycle, the states SQ_L, SQ_R
// and SQ_X on one 24 x 24 multiplier and a final accumulate. A block end adds the two
// restoring divisions by n and two square roots of SQW bits (one bit per cycle), then, in
// stereo with non-zero sums, the shift-add product, its root and the correlation quotient,
// and then smoothing and output (SQW = 59 by default).
// Reset clears all levels and the block accumulators.
// A result waiting in the output register only stalls the next item at its own output.
`timescale 1ns / 1ps
module stereo_level_meter_top import slm_pkg::*; #(
	parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	slm_in_if.sink     sample_ch,
	slm_out_if.source  result_ch,
	slm_cfg_if.sink    cfg_ch
);

	localparam int CW  = $clog2(BLOCK_MAX + 1);
	localparam int SQW = 2 * SAMPLE_BITS - 1 + $clog2(BLOCK_MAX);
	localparam int PW  = 2 * SQW;
	localparam int SW  = $clog2(SQW + 1);
	localparam int SB  = SAMPLE_BITS;
	localparam logic [CW-1:0] BLOCK_LAST = CW'(BLOCK_MAX);

	state_t state_q, state_nx;

	// Configuration registers.
	logic                stereo_q;
	logic [COEF_W-1:0]   smooth_q;
	logic [LEVEL_W-1:0]  pfall_q, hfall_q;

	// Meter levels.
	logic [LEVEL_W-1:0]       peak_l_q, peak_r_q, hold_l_q, hold_r_q, rms_l_q, rms_r_q;
	logic signed [CORR_W-1:0] corr_q;

	// Block accumulators.
	logic [SB-1:0]       bmax_l_q, bmax_r_q;
	logic [SQW-1:0]      sum_l_q, sum_r_q;
	logic signed [SQW:0] cross_q;
	logic [CW-1:0]       count_q;

	// Current sample.
	logic [SB-1:0]   mag_l_q, mag_r_q;
	logic            xneg_q, last_q;
	logic [2*SB-1:0] prod_q;

	// Serial arithmetic registers.
	logic [SQW-1:0]           dq_q;
	logic [CW-1:0]            drem_q;
	logic [PW-1:0]            rad_q, mc_q;
	logic [SQW-1:0]           root_q;
	logic [SQW+1:0]           srem_q;
	logic [SQW:0]             crem_q;
	logic [CORR_QW-1:0]       cq_q;
	logic [SW-1:0]            step_q;
	logic [LEVEL_W-1:0]       rl_q, rr_q;
	logic signed [CORR_W-1:0] ctgt_q;

	// Output register.
	logic                     out_v_q;
	logic [LEVEL_W-1:0]       o_pl_q, o_pr_q, o_hl_q, o_hr_q, o_rl_q, o_rr_q;
	logic signed [CORR_W-1:0] o_c_q;

	// Combinational helpers.
	logic                in_acc, out_free, loop_last, cdiv_last, block_end, corr_path;
	logic [CW-1:0]       cnt_nx;
	logic [CW:0]         dt;
	logic                dge;
	logic [SQW-1:0]      dq_nx;
	logic [SQW+3:0]      st, strial;
	logic                sge;
	logic [SQW-1:0]      root_nx;
	logic [SQW:0]        crs;
	logic                cge;
	logic [CORR_QW-1:0]  cq_nx, cq_cl;
	logic [COEF_W-1:0]   coef_eff;
	logic signed [SB-1:0] l_in, r_in;
	logic [SQW-1:0]      cross_mag;

	function automatic logic signed [25:0] smooth_step(input logic signed [25:0] cur,
		input logic signed [25:0] tgt, input logic [COEF_W-1:0] coef);
		logic signed [25:0] diff;
		logic signed [43:0] prod;
		diff = tgt - cur;
		prod = diff * $signed({1'b0, coef});
		prod = prod + 44'sd32768;
		return cur + 26'(prod >>> 16);
	endfunction

	function automatic logic [LEVEL_W-1:0] sat_sub(input logic [LEVEL_W-1:0] a,
		input logic [LEVEL_W-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	// Handshake and loop control.
	assign in_acc    = sample_ch.valid && sample_ch.ready;
	assign out_free  = !out_v_q || result_ch.ready;
	assign loop_last = (step_q == SW'(SQW - 1));
	assign cdiv_last = (step_q == SW'(CORR_QW - 1));
	assign cnt_nx    = count_q + 1'b1;
	assign block_end = last_q || (cnt_nx == BLOCK_LAST);
	assign corr_path = stereo_q && (sum_l_q != '0) && (sum_r_q != '0);
	assign coef_eff  = (smooth_q > UNITY_Q16) ? UNITY_Q16 : smooth_q;
	assign l_in      = sample_ch.left_sample;
	assign r_in      = stereo_q ? sample_ch.right_sample : sample_ch.left_sample;
	assign cross_mag = cross_q[SQW] ? SQW'(-cross_q) : SQW'(cross_q);

	// One restoring division step by the block length.
	always_comb begin
		dt    = {drem_q, dq_q[SQW-1]};
		dge   = (dt >= {1'b0, count_q});
		dq_nx = {dq_q[SQW-2:0], dge};
	end

	// One restoring square-root step, two radicand bits at a time.
	always_comb begin
		st      = {srem_q, rad_q[PW-1:PW-2]};
		strial  = {2'b00, root_q, 2'b01};
		sge     = (st >= strial);
		root_nx = {root_q[SQW-2:0], sge};
	end

	// One correlation quotient step; the first step compares without a shift.
	always_comb begin
		crs   = (step_q == '0) ? crem_q : {crem_q[SQW-1:0], 1'b0};
		cge   = (crs >= {1'b0, root_q});
		cq_nx = {cq_q[CORR_QW-2:0], cge};
		cq_cl = (cq_nx > CORR_QW'(CORR_ONE)) ? CORR_QW'(CORR_ONE) : cq_nx;
	end

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_nx = (sample_ch.opcode == OP_TICK) ? ST_TICK : ST_SQ_L;
			ST_SQ_L:  state_nx = ST_SQ_R;
			ST_SQ_R:  state_nx = ST_SQ_X;
			ST_SQ_X:  state_nx = ST_ACC_X;
			ST_ACC_X: state_nx = block_end ? ST_DIV_L : ST_IDLE;
			ST_DIV_L: if (loop_last) state_nx = ST_RT_L;
			ST_RT_L:  if (loop_last) state_nx = ST_DIV_R;
			ST_DIV_R: if (loop_last) state_nx = ST_RT_R;
			ST_RT_R:  if (loop_last) state_nx = corr_path ? ST_CMUL : ST_SM_L;
			ST_CMUL:  if (loop_last) state_nx = ST_CRT;
			ST_CRT:   if (loop_last) state_nx = ST_CDIV;
			ST_CDIV:  if (cdiv_last) state_nx = ST_SM_L;
			ST_SM_L:  state_nx = ST_SM_R;
			ST_SM_R:  state_nx = ST_SM_C;
			ST_SM_C:  state_nx = ST_OUT;
			ST_TICK:  state_nx = ST_OUT;
			ST_OUT:   if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Port outputs.
	always_comb begin
		sample_ch.ready              = (state_q == ST_IDLE);
		cfg_ch.ready                 = 1'b1;
		result_ch.valid              = out_v_q;
		result_ch.peak_left          = o_pl_q;
		result_ch.peak_right         = o_pr_q;
		result_ch.hold_left          = o_hl_q;
		result_ch.hold_right         = o_hr_q;
		result_ch.rms_left_out       = o_rl_q;
		result_ch.rms_right_out      = o_rr_q;
		result_ch.stereo_correlation = o_c_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b1;
			smooth_q <= 17'd6554;
			pfall_q  <= 24'd8389;
			hfall_q  <= 24'd839;
		end else if (cfg_ch.valid) begin
			case (cfg_idx_t'(cfg_ch.index))
				CFG_STEREO_MODE:   stereo_q <= cfg_ch.data[0];
				CFG_RMS_SMOOTHING: smooth_q <= cfg_ch.data[COEF_W-1:0];
				CFG_PEAK_FALLOFF:  pfall_q  <= cfg_ch.data[LEVEL_W-1:0];
				CFG_HOLD_FALLOFF:  hfall_q  <= cfg_ch.data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Output register: loaded when a result is ready and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_v_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			o_pl_q <= peak_l_q;
			o_pr_q <= peak_r_q;
			o_hl_q <= hold_l_q;
			o_hr_q <= hold_r_q;
			o_rl_q <= rms_l_q;
			o_rr_q <= rms_r_q;
			o_c_q  <= corr_q;
		end
	end

	// Levels and block accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_l_q <= '0;
			peak_r_q <= '0;
			hold_l_q <= '0;
			hold_r_q <= '0;
			rms_l_q  <= '0;
			rms_r_q  <= '0;
			corr_q   <= '0;
			bmax_l_q <= '0;
			bmax_r_q <= '0;
			sum_l_q  <= '0;
			sum_r_q  <= '0;
			cross_q  <= '0;
			count_q  <= '0;
		end else begin
			case (state_q)
				ST_SQ_L: begin
					if (mag_l_q > bmax_l_q) bmax_l_q <= mag_l_q;
					if (mag_r_q > bmax_r_q) bmax_r_q <= mag_r_q;
				end
				ST_SQ_R: sum_l_q <= sum_l_q + SQW'(prod_q);
				ST_SQ_X: sum_r_q <= sum_r_q + SQW'(prod_q);
				ST_ACC_X: begin
					cross_q <= xneg_q ? cross_q - (SQW+1)'(prod_q)
						: cross_q + (SQW+1)'(prod_q);
					count_q <= cnt_nx;
					if (block_end) begin
						if (bmax_l_q > peak_l_q) peak_l_q <= bmax_l_q;
						if (bmax_r_q > peak_r_q) peak_r_q <= bmax_r_q;
						if (bmax_l_q > hold_l_q) hold_l_q <= bmax_l_q;
						if (bmax_r_q > hold_r_q) hold_r_q <= bmax_r_q;
					end
				end
				ST_SM_L: rms_l_q <= LEVEL_W'(smooth_step(26'(rms_l_q), 26'(rl_q), coef_eff));
				ST_SM_R: rms_r_q <= LEVEL_W'(smooth_step(26'(rms_r_q), 26'(rr_q), coef_eff));
				ST_SM_C: begin
					corr_q   <= stereo_q ? CORR_W'(smooth_step(26'(corr_q), 26'(ctgt_q),
						CORR_COEF)) : CORR_ONE;
					bmax_l_q <= '0;
					bmax_r_q <= '0;
					sum_l_q  <= '0;
					sum_r_q  <= '0;
					cross_q  <= '0;
					count_q  <= '0;
				end
				ST_TICK: begin
					peak_l_q <= sat_sub(peak_l_q, pfall_q);
					peak_r_q <= sat_sub(peak_r_q, pfall_q);
					hold_l_q <= sat_sub(hold_l_q, hfall_q);
					hold_r_q <= sat_sub(hold_r_q, hfall_q);
				end
				default: ;
			endcase
		end
	end

	// Sample capture, multiplier and serial units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			case (state_q)
				ST_DIV_L, ST_RT_L, ST_DIV_R, ST_RT_R, ST_CMUL, ST_CRT:
					step_q <= loop_last ? '0 : step_q + 1'b1;
				ST_CDIV: step_q <= cdiv_last ? '0 : step_q + 1'b1;
				default: step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mag_l_q <= l_in[SB-1] ? SB'(-l_in) : SB'(l_in);
					mag_r_q <= r_in[SB-1] ? SB'(-r_in) : SB'(r_in);
					xneg_q  <= l_in[SB-1] ^ r_in[SB-1];
					last_q  <= sample_ch.last_in_block;
				end
			end
			ST_SQ_L: prod_q <= mag_l_q * mag_l_q;
			ST_SQ_R: prod_q <= mag_r_q * mag_r_q;
			ST_SQ_X: prod_q <= mag_l_q * mag_r_q;
			ST_ACC_X: begin
				dq_q   <= sum_l_q;
				drem_q <= '0;
			end
			ST_DIV_L, ST_DIV_R: begin
				drem_q <= dge ? CW'(dt - {1'b0, count_q}) : dt[CW-1:0];
				dq_q   <= dq_nx;
				if (loop_last) begin
					rad_q  <= {{SQW{1'b0}}, dq_nx};
					root_q <= '0;
					srem_q <= '0;
				end
			end
			ST_RT_L, ST_RT_R, ST_CRT: begin
				srem_q <= sge ? (SQW+2)'(st - strial) : st[SQW+1:0];
				root_q <= root_nx;
				rad_q  <= {rad_q[PW-3:0], 2'b00};
				if (loop_last && state_q == ST_RT_L) begin
					rl_q   <= LEVEL_W'(root_nx);
					dq_q   <= sum_r_q;
					drem_q <= '0;
				end
				if (loop_last && state_q == ST_RT_R) begin
					rr_q   <= LEVEL_W'(root_nx);
					ctgt_q <= CORR_ONE;
					rad_q  <= '0;
					mc_q   <= {{SQW{1'b0}}, sum_l_q};
					dq_q   <= sum_r_q;
				end
				if (loop_last && state_q == ST_CRT) begin
					crem_q <= {1'b0, cross_mag};
					cq_q   <= '0;
				end
			end
			ST_CMUL: begin
				rad_q <= rad_q + (dq_q[0] ? mc_q : '0);
				mc_q  <= {mc_q[PW-2:0], 1'b0};
				dq_q  <= {1'b0, dq_q[SQW-1:1]};
				if (loop_last) begin
					root_q <= '0;
					srem_q <= '0;
				end
			end
			ST_CDIV: begin
				crem_q <= cge ? crs - {1'b0, root_q} : crs;
				cq_q   <= cq_nx;
				if (cdiv_last) begin
					ctgt_q <= cross_q[SQW] ? -$signed({1'b0, cq_cl}) : $signed({1'b0, cq_cl});
				end
			end
			default: ;
		endcase
	end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the stereo level meter: directed and random stimulus.
`timescale 1ns / 1ps
module testbench import slm_pkg::*; ();

	// Snapshot of every level that one result transfer carries.
	typedef struct packed {
		logic [LEVEL_W-1:0] peak_l;
		logic [LEVEL_W-1:0] peak_r;
		logic [LEVEL_W-1:0] hold_l;
		logic [LEVEL_W-1:0] hold_r;
		logic [LEVEL_W-1:0] rms_l;
		logic [LEVEL_W-1:0] rms_r;
		logic [CORR_W-1:0]  corr;
	} levels_t;

	logic clk;
	logic arst_n;

	slm_in_if  sample_ch ();
	slm_out_if result_ch ();
	slm_cfg_if cfg_ch ();

	stereo_level_meter_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	// Meter state as the testbench believes it to be.
	logic   mode_stereo;
	longint smooth_coef, peak_fall, hold_fall;
	longint peak_l, peak_r, hold_l, hold_r, rms_l, rms_r, corr_lv;
	longint max_l, max_r, sq_l, sq_r, xsum, n_samples;

	levels_t levels_q[$];
	int      mismatches;
	int      results_seen;
	int      items_sent;
	int      blocks_ended;
	int      ticks_sent;
	bit      quiet;

	// Clock generation.
	always #2 clk = ~clk;

	// Floor square root of a value up to 128 bits wide.
	function automatic longint floor_sqrt(input logic [127:0] v);
		logic [63:0]  root;
		logic [63:0]  trial;
		logic [127:0] sq;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			sq = {64'd0, trial} * {64'd0, trial};
			if (sq <= v)
				root = trial;
		end
		return longint'(root);
	endfunction

	// One smoothing step: cur plus the rounded, floored fraction of the gap.
	function automatic longint smooth_toward(input longint cur, input longint target,
			input longint coef);
		longint prod;
		prod = coef * (target - cur) + 32768;
		return cur + (prod >>> 16);
	endfunction

	// Correlation of the block just ended, Q1.14.
	function automatic longint block_correlation();
		logic [127:0] prod;
		longint den, rem, quo;
		if (sq_l == 0 || sq_r == 0)
			return 16384;
		prod = {64'd0, sq_l} * {64'd0, sq_r};
		den = floor_sqrt(prod);
		rem = xsum < 0 ? -xsum : xsum;
		quo = 0;
		if (rem >= den) begin
			quo = 1;
			rem -= den;
		end
		for (int i = 0; i < 14; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= den) begin
				quo |= 1;
				rem -= den;
			end
		end
		if (quo > 16384)
			quo = 16384;
		return xsum < 0 ? -quo : quo;
	endfunction

	function automatic levels_t current_levels();
		levels_t lv;
		lv.peak_l = peak_l[23:0];
		lv.peak_r = peak_r[23:0];
		lv.hold_l = hold_l[23:0];
		lv.hold_r = hold_r[23:0];
		lv.rms_l  = rms_l[23:0];
		lv.rms_r  = rms_r[23:0];
		lv.corr   = corr_lv[15:0];
		return lv;
	endfunction

	// Advances the predicted meter by one accepted item.
	task automatic update_meter(input logic op, input logic signed [23:0] ls,
			input logic signed [23:0] rs, input logic last);
		longint lv, rv, ml, mr, coef;
		if (op == OP_TICK) begin
			peak_l = peak_l > peak_fall ? peak_l - peak_fall : 0;
			peak_r = peak_r > peak_fall ? peak_r - peak_fall : 0;
			hold_l = hold_l > hold_fall ? hold_l - hold_fall : 0;
			hold_r = hold_r > hold_fall ? hold_r - hold_fall : 0;
			levels_q.push_back(current_levels());
			return;
		end
		lv = longint'(ls);
		rv = mode_stereo ? longint'(rs) : lv;
		ml = lv < 0 ? -lv : lv;
		mr = rv < 0 ? -rv : rv;
		if (ml > max_l) max_l = ml;
		if (mr > max_r) max_r = mr;
		sq_l += lv * lv;
		sq_r += rv * rv;
		xsum += lv * rv;
		n_samples++;
		if (!last && n_samples < BLOCK_MAX_DEF)
			return;
		if (max_l > peak_l) peak_l = max_l;
		if (max_r > peak_r) peak_r = max_r;
		if (max_l > hold_l) hold_l = max_l;
		if (max_r > hold_r) hold_r = max_r;
		coef = smooth_coef > 65536 ? 65536 : smooth_coef;
		rms_l = smooth_toward(rms_l, floor_sqrt(128'(sq_l / n_samples)), coef);
		rms_r = smooth_toward(rms_r, floor_sqrt(128'(sq_r / n_samples)), coef);
		if (mode_stereo)
			corr_lv = smooth_toward(corr_lv, block_correlation(), 3277);
		else
			corr_lv = 16384;
		max_l = 0;
		max_r = 0;
		sq_l = 0;
		sq_r = 0;
		xsum = 0;
		n_samples = 0;
		blocks_ended++;
		levels_q.push_back(current_levels());
	endtask

	// Offers one item and waits for its transfer; valid stays high afterwards.
	// Ready is sampled at the falling edge, where it holds its value for the next rising edge.
	task automatic send_item(input logic op, input logic signed [23:0] ls,
			input logic signed [23:0] rs, input logic last);
		logic rdy;
		if (!quiet && $urandom_range(99) < 24) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		sample_ch.valid         <= 1'b1;
		sample_ch.opcode        <= op;
		sample_ch.left_sample   <= ls;
		sample_ch.right_sample  <= rs;
		sample_ch.last_in_block <= last;
		do begin
			@(negedge clk);
			rdy = sample_ch.ready;
			@(posedge clk);
		end while (!rdy);
		update_meter(op, ls, rs, last);
		items_sent++;
		if (op == OP_TICK) ticks_sent++;
	endtask

	// Stops offering items and waits until the meter has gone quiet.
	task automatic drain(input int settle);
		sample_ch.valid <= 1'b0;
		while (levels_q.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Writes all four registers in turn; only called while the meter is idle.
	task automatic set_config(input logic mode, input logic [23:0] coef,
			input logic [23:0] pfall, input logic [23:0] hfall);
		logic [23:0] vals[4];
		vals = '{{23'd0, mode}, coef, pfall, hfall};
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= cfg_idx_t'(i);
			cfg_ch.data  <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			case (cfg_idx_t'(i))
				CFG_STEREO_MODE:   mode_stereo = vals[i][0];
				CFG_RMS_SMOOTHING: smooth_coef = vals[i] & 24'h1FFFF;
				CFG_PEAK_FALLOFF:  peak_fall = vals[i];
				CFG_HOLD_FALLOFF:  hold_fall = vals[i];
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Sample value drawn from a mix of full range, small values and extremes.
	function automatic logic signed [23:0] pick_sample();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(2000)) - 1000);
			2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			default: return $urandom_range(1) ? 24'sd0 : 24'($urandom);
		endcase
	endfunction

	// Random back-pressure on the result channel.
	always @(posedge clk)
		result_ch.ready <= quiet || $urandom_range(99) >= 24;

	// Result checking; handshake and fields are stable at the falling edge before the
	// rising edge that completes the transfer.
	always @(negedge clk) begin
		levels_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = {result_ch.peak_left, result_ch.peak_right, result_ch.hold_left,
				result_ch.hold_right, result_ch.rms_left_out, result_ch.rms_right_out,
				result_ch.stereo_correlation};
			results_seen++;
			if (levels_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transfer: %p", got);
			end else begin
				want = levels_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch on result %0d:\n  expected %p\n  actual   %p",
							results_seen, want, got);
				end
			end
		end
	end

	// Default registers, ticks and one block straight after reset.
	task automatic test_reset_state();
		send_item(OP_TICK, 24'sd0, 24'sd0, 1'b0);
		send_item(OP_SAMPLE, 24'sd1000, -24'sd1000, 1'b0);
		send_item(OP_SAMPLE, 24'sd3000, 24'sd500, 1'b1);
		send_item(OP_TICK, 24'sh7FFFFF, 24'sh800000, 1'b1);
		drain(20);
	endtask

	// Field extremes, zero sums, opposite signs, mono and smoothing limits.
	task automatic test_extremes();
		set_config(1'b1, 24'd65536, 24'd0, 24'd0);
		send_item(OP_SAMPLE, 24'sh800000, 24'sh800000, 1'b1);
		send_item(OP_SAMPLE, 24'sh7FFFFF, 24'sh800000, 1'b1);
		send_item(OP_SAMPLE, 24'sd0, 24'sd12345, 1'b1);
		send_item(OP_SAMPLE, 24'sd0, 24'sd0, 1'b1);
		send_item(OP_TICK, 24'sd0, 24'sd0, 1'b0);
		drain(20);
		set_config(1'b1, 24'hFFFFFF, 24'd8388608, 24'd8388608);
		send_item(OP_SAMPLE, -24'sd1, 24'sd1, 1'b0);
		send_item(OP_TICK, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
		send_item(OP_SAMPLE, 24'sh555555, -24'sh2AAAAA, 1'b1);
		send_item(OP_TICK, 24'sd0, 24'sd0, 1'b0);
		send_item(OP_TICK, 24'sd0, 24'sd0, 1'b0);
		drain(20);
		set_config(1'b0, 24'd0, 24'd1, 24'd8388607);
		send_item(OP_SAMPLE, 24'sh800000, 24'sd7, 1'b0);
		send_item(OP_SAMPLE, 24'sd42, 24'sh7FFFFF, 1'b1);
		send_item(OP_TICK, 24'sd0, 24'sd0, 1'b0);
		drain(20);
		set_config(1'b1, 24'd65537, 24'd8389, 24'd839);
		send_item(OP_SAMPLE, 24'sd100000, 24'sd90000, 1'b0);
		send_item(OP_SAMPLE, -24'sd100000, -24'sd95000, 1'b1);
		drain(20);
	endtask

	// A block with no last mark that closes itself at the size limit.
	task automatic test_overlong_block();
		set_config(1'b1, 24'd20000, 24'd8389, 24'd839);
		for (int i = 0; i < BLOCK_MAX_DEF; i++)
			send_item(OP_SAMPLE, pick_sample(), pick_sample(), 1'b0);
		send_item(OP_SAMPLE, 24'sd5, 24'sd5, 1'b1);
		drain(20);
	endtask

	// Random blocks and ticks under changing register settings.
	task automatic test_random_traffic();
		int sent, len;
		sent = 0;
		while (sent < 1000) begin
			if (sent % 120 == 0) begin
				drain(20);
				set_config($urandom_range(3) != 0, $urandom_range(1) ? 24'($urandom_range(65536))
					: 24'($urandom), 24'($urandom_range(200000)), $urandom_range(3) == 0
					? 24'd8388608 : 24'($urandom_range(20000)));
			end
			quiet = sent >= 450 && sent < 650;
			len = $urandom_range(9) == 0 ? $urandom_range(9, 64) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0) begin
					send_item(OP_TICK, 24'($urandom), 24'($urandom), 1'($urandom_range(1)));
					sent++;
				end
				send_item(OP_SAMPLE, pick_sample(), pick_sample(), i == len - 1);
				sent++;
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.opcode = OP_SAMPLE;
		sample_ch.left_sample = '0;
		sample_ch.right_sample = '0;
		sample_ch.last_in_block = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_STEREO_MODE;
		cfg_ch.data = '0;
		mode_stereo = 1'b1;
		smooth_coef = 6554;
		peak_fall = 8389;
		hold_fall = 839;
		{peak_l, peak_r, hold_l, hold_r, rms_l, rms_r, corr_lv} = '0;
		{max_l, max_r, sq_l, sq_r, xsum, n_samples} = '0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		blocks_ended = 0;
		ticks_sent = 0;
		quiet = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_extremes();
		test_overlong_block();
		test_random_traffic();
		drain(600);

		$display("Sent %0d items: %0d blocks ended, %0d decay ticks, %0d results checked.",
			items_sent, blocks_ended, ticks_sent, results_seen);
		$display("Mismatches: %0d.", mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#40_000_000;
		$display("Timed out with %0d results outstanding.", levels_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
rtl/slm_pkg.sv
rtl/slm_in_if.sv
rtl/slm_out_if.sv
rtl/slm_cfg_if.sv
rtl/stereo_level_meter_top.sv
test/testbench.sv
